/* rtl/crc8pd_pkg.sv */
// ----------------------------------------------------------------------------
// crc8pd_pkg
// Shared types, constants and the CRC-8 byte update for the packet deframer.
// ----------------------------------------------------------------------------
package crc8pd_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'd1;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

    // Byte that aborts a hunt; a timeout also reads as this byte.
    localparam logic [BYTE_W-1:0] ABORT_BYTE = 8'hFF;

    // CRC-8 settings: poly 0x07, init 0xFF, MSB first.
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

    // Byte positions after the start marker.
    localparam logic [POS_W-1:0] POS_COMMAND = 3'd0;
    localparam logic [POS_W-1:0] POS_TABLE   = 3'd1;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 3'd2;
    localparam logic [POS_W-1:0] POS_CHECK   = 3'd3;
    localparam logic [POS_W-1:0] POS_END     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_VALID      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_END    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CRC    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HUNT_ABORT = 2'd3;

    // One result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   command;
        logic [BYTE_W-1:0]   table_index;
        logic [BYTE_W-1:0]   payload;
        logic [BYTE_W-1:0]   received_check;
    } result_t;

    // Feed one byte into the CRC, eight shift steps unrolled.
    function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/crc8pd_rx_if.sv */
// ----------------------------------------------------------------------------
// crc8pd_rx_if
// Receive byte channel: one received byte or a timeout flag per beat.
// ----------------------------------------------------------------------------
interface crc8pd_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       timed_out;

    modport source (output valid, output rx_byte, output timed_out, input ready);
    modport sink   (input valid, input rx_byte, input timed_out, output ready);

endinterface

/* rtl/crc8pd_res_if.sv */
// ----------------------------------------------------------------------------
// crc8pd_res_if
// Result channel: one decoded packet or hunt abort per beat.
// ----------------------------------------------------------------------------
interface crc8pd_res_if;

    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] command;
    logic [7:0] table_index;
    logic [7:0] payload;
    logic [7:0] received_check;

    modport source (output valid, output status, output command, output table_index,
                    output payload, output received_check, input ready);
    modport sink   (input valid, input status, input command, input table_index,
                    input payload, input received_check, output ready);

endinterface

/* rtl/crc8pd_frame.sv */
// ----------------------------------------------------------------------------
// crc8pd_frame
// Framing state, field capture, running CRC and configuration registers.
// ----------------------------------------------------------------------------
module crc8pd_frame (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crc8pd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crc8pd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                beat_accept,
    input  logic [crc8pd_pkg::BYTE_W-1:0]       rx_byte,
    input  logic                                timed_out,
    output logic                                res_valid,
    output crc8pd_pkg::result_t                 res_data
);
    import crc8pd_pkg::*;

    logic                start_sel;
    logic [BYTE_W-1:0]   start_value_reg;
    logic [BYTE_W-1:0]   end_value_reg;
    logic                collecting_reg, collecting_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [BYTE_W-1:0]   command_reg, command_next;
    logic [BYTE_W-1:0]   table_reg, table_next;
    logic [BYTE_W-1:0]   payload_reg, payload_next;
    logic [BYTE_W-1:0]   check_reg, check_next;
    logic [BYTE_W-1:0]   crc_reg, crc_next;
    logic [BYTE_W-1:0]   b;
    logic [BYTE_W-1:0]   crc_fed;

    // A write with the start marker index goes to the start marker register.
    assign start_sel = (cfg_index == REG_START_MARKER);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= START_MARKER_RST;
            end_value_reg   <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            if (start_sel)
                start_value_reg <= cfg_data;
            else
                end_value_reg <= cfg_data;
        end
    end

    // A timeout reads as the abort byte.
    assign b       = timed_out ? ABORT_BYTE : rx_byte;
    assign crc_fed = crc8_feed(crc_reg, b);

    // Next state and result for the current beat.
    always_comb
    begin
        collecting_next = collecting_reg;
        position_next   = position_reg;
        command_next    = command_reg;
        table_next      = table_reg;
        payload_next    = payload_reg;
        check_next      = check_reg;
        crc_next        = crc_reg;
        res_valid       = 1'b0;
        res_data        = '{status: ST_HUNT_ABORT, command: '0, table_index: '0,
                            payload: '0, received_check: '0};
        if (beat_accept)
        begin
            if (!collecting_reg)
            begin
                // Hunting for the start marker.
                if (b == ABORT_BYTE)
                    res_valid = 1'b1;
                else if (b == start_value_reg)
                begin
                    collecting_next = 1'b1;
                    position_next   = POS_COMMAND;
                    crc_next        = CRC_INIT;
                end
            end
            else
            begin
                unique case (position_reg)
                    POS_COMMAND:
                    begin
                        command_next  = b;
                        crc_next      = crc_fed;
                        position_next = POS_TABLE;
                    end
                    POS_TABLE:
                    begin
                        table_next    = b;
                        crc_next      = crc_fed;
                        position_next = POS_PAYLOAD;
                    end
                    POS_PAYLOAD:
                    begin
                        payload_next  = b;
                        crc_next      = crc_fed;
                        position_next = POS_CHECK;
                    end
                    POS_CHECK:
                    begin
                        check_next    = b;
                        position_next = POS_END;
                    end
                    default:
                    begin
                        // End marker byte, and any stray position.
                        res_valid               = 1'b1;
                        res_data.command        = command_reg;
                        res_data.table_index    = table_reg;
                        res_data.payload        = payload_reg;
                        res_data.received_check = check_reg;
                        if (b != end_value_reg)
                            res_data.status = ST_BAD_END;
                        else if (crc_reg != check_reg)
                            res_data.status = ST_BAD_CRC;
                        else
                            res_data.status = ST_VALID;
                        collecting_next = 1'b0;
                        position_next   = POS_COMMAND;
                        crc_next        = CRC_INIT;
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            position_reg   <= POS_COMMAND;
            crc_reg        <= CRC_INIT;
        end
        else
        begin
            collecting_reg <= collecting_next;
            position_reg   <= position_next;
            crc_reg        <= crc_next;
        end
    end

    // Captured packet fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= '0;
            table_reg   <= '0;
            payload_reg <= '0;
            check_reg   <= '0;
        end
        else
        begin
            command_reg <= command_next;
            table_reg   <= table_next;
            payload_reg <= payload_next;
            check_reg   <= check_next;
        end
    end

endmodule

/* rtl/crc8pd_out_reg.sv */
// ----------------------------------------------------------------------------
// crc8pd_out_reg
// Result register that holds a beat until the consumer takes it.
// ----------------------------------------------------------------------------
module crc8pd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  crc8pd_pkg::result_t load_data,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output crc8pd_pkg::result_t out_data
);
    import crc8pd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Room for a new result when empty or when the held one leaves now.
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/crc8_packet_deframer_checker.sv */
// ----------------------------------------------------------------------------
// crc8_packet_deframer_checker
// STX/ETX packet deframer with a CRC-8 check over command, index and payload.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle; the input stalls only while a result
// waits in the output register and the result channel is not ready.
// A result appears on the result channel in the cycle after the byte that ends
// the packet or aborts the hunt.
// Reset: asynchronous, active low; the block hunts for a start marker with the
// markers at 0x02 and 0x03 and no result pending.
module crc8_packet_deframer_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crc8pd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crc8pd_pkg::CFG_DATA_W-1:0]   cfg_data,
    crc8pd_rx_if.sink                           rx,
    crc8pd_res_if.source                        res
);
    import crc8pd_pkg::*;

    logic    beat_accept;
    logic    can_load;
    logic    frame_valid;
    result_t frame_data;
    result_t out_data;

    // A byte is taken whenever the result register has room.
    assign rx.ready    = can_load;
    assign beat_accept = rx.valid && can_load;

    crc8pd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .beat_accept (beat_accept),
        .rx_byte     (rx.rx_byte),
        .timed_out   (rx.timed_out),
        .res_valid   (frame_valid),
        .res_data    (frame_data)
    );

    crc8pd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (frame_valid),
        .load_data (frame_data),
        .can_load  (can_load),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (out_data)
    );

    // Result channel payload.
    assign res.status         = out_data.status;
    assign res.command        = out_data.command;
    assign res.table_index    = out_data.table_index;
    assign res.payload        = out_data.payload;
    assign res.received_check = out_data.received_check;

endmodule
